// ===== src/neighbour_agreement_test_unit_assert.svh =====
// Assertion macros shared by the neighbour agreement test unit.
`ifndef NEIGHBOUR_AGREEMENT_TEST_UNIT_ASSERT_SVH
`define NEIGHBOUR_AGREEMENT_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define NAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define NAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nat_pkg.sv =====
// Package of shared constants and types for the neighbour agreement test unit.
package nat_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_FRAMES = 256;

  localparam int PIXEL_BITS     = 8;
  localparam int COUNT_BITS     = 22;
  localparam int WIDTH_BITS     = 7;
  localparam int HEIGHT_BITS    = 7;
  localparam int FRAMES_BITS    = 9;
  localparam int PERMILLE_BITS  = 10;
  localparam int CFG_DATA_BITS  = 10;
  localparam int PERMILLE_SCALE = 1000;

  localparam logic [WIDTH_BITS-1:0]    RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [HEIGHT_BITS-1:0]   RST_IMAGE_HEIGHT = 7'd64;
  localparam logic [FRAMES_BITS-1:0]   RST_FRAME_COUNT  = 9'd1;
  localparam logic [PERMILLE_BITS-1:0] RST_AGREE_THRESH = 10'd600;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FRAME_COUNT  = 2'd2,
    REG_AGREE_THRESH = 2'd3
  } cfg_index_t;

endpackage

// ===== src/neighbour_agreement_test_unit.sv =====
// Top level of the neighbour agreement test unit.
// Pixels enter in raster order (frame, row, column) at one item per clock. The line store and
// the frame store are synchronous RAMs with a separate read and write port; each accepted pixel
// reads and overwrites its own entry in the same cycle, so back-to-back pixels never wait on
// them. Each pixel is compared with its left neighbour, the pixel above and the same pixel of
// the previous frame. The result item of a unit passes from the pixel stage through verdict
// stages a and b to the result register, and further pixels are taken while it waits. Up to
// three finished results can be held; only when a fourth unit ends behind them does the input
// stall until the result side takes one. A configuration write restarts the unit; it must be
// issued only while the block is idle. Both stores need no clearing after reset.
module neighbour_agreement_test_unit #(
  parameter int MAX_WIDTH  = nat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nat_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_FRAMES = nat_pkg::DEF_MAX_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  nat_pkg::cfg_index_t               cfg_index,
  input  logic [nat_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [nat_pkg::PIXEL_BITS-1:0]    pixel,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              unit_passes,
  output logic [nat_pkg::COUNT_BITS-1:0]    equal_pairs,
  output logic [nat_pkg::COUNT_BITS-1:0]    total_pairs
);
  import nat_pkg::*;

`include "neighbour_agreement_test_unit_assert.svh"

  localparam int    DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int    XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int    YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int    FW        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int    SW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int    WW        = $clog2(MAX_WIDTH + 1);
  localparam int    HW        = $clog2(MAX_HEIGHT + 1);
  localparam int    FCW       = $clog2(MAX_FRAMES + 1);
  localparam longint MAX_PAIRS = 3 * longint'(DEPTH) * longint'(MAX_FRAMES);
  localparam int    CNT_W     = $clog2(MAX_PAIRS + 1);

  logic [WIDTH_BITS-1:0]    image_width;
  logic [HEIGHT_BITS-1:0]   image_height;
  logic [FRAMES_BITS-1:0]   frame_count;
  logic [PERMILLE_BITS-1:0] agree_thresh;

  logic [WW-1:0]  w_lim;
  logic [HW-1:0]  h_lim;
  logic [FCW-1:0] f_lim;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [FW-1:0] frame;
  logic [SW-1:0] row_base;
  logic [SW-1:0] slot;
  logic          col_last;
  logic          row_last;
  logic          frame_last;

  logic [PIXEL_BITS-1:0] left_pixel;
  logic [PIXEL_BITS-1:0] line_rd;
  logic [PIXEL_BITS-1:0] frame_rd;

  logic                  s1_valid;
  logic                  s1_last;
  logic                  s1_has_left;
  logic                  s1_has_up;
  logic                  s1_has_prev;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic [PIXEL_BITS-1:0] s1_left;
  logic                  s1_go;

  logic [1:0]       eq_inc;
  logic [1:0]       pair_inc;
  logic [CNT_W-1:0] eq_count;
  logic [CNT_W-1:0] pr_count;
  logic [CNT_W-1:0] eq_sum;
  logic [CNT_W-1:0] pr_sum;

  logic fin_valid;
  logic fin_ready;
  logic cfg_fire;
  logic accept;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      frame_count  <= RST_FRAME_COUNT;
      agree_thresh <= RST_AGREE_THRESH;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
        REG_FRAME_COUNT:  frame_count  <= cfg_data[FRAMES_BITS-1:0];
        REG_AGREE_THRESH: agree_thresh <= cfg_data[PERMILLE_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_lim = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(image_width);
    end
    if (image_height == '0) begin
      h_lim = HW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(image_height);
    end
    if (frame_count == '0) begin
      f_lim = FCW'(1);
    end else if (int'(frame_count) > MAX_FRAMES) begin
      f_lim = FCW'(MAX_FRAMES);
    end else begin
      f_lim = FCW'(frame_count);
    end
  end

  assign col_last   = (col == XW'(w_lim - WW'(1)));
  assign row_last   = (row == YW'(h_lim - HW'(1)));
  assign frame_last = (frame == FW'(f_lim - FCW'(1)));
  assign slot       = row_base + SW'(col);

  assign s1_go       = s1_valid && (!s1_last || fin_ready);
  assign pixel_ready = !s1_valid || s1_go;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      col      <= '0;
      row      <= '0;
      frame    <= '0;
      row_base <= '0;
    end else if (accept) begin
      if (!col_last) begin
        col <= col + XW'(1);
      end else begin
        col <= '0;
        if (!row_last) begin
          row      <= row + YW'(1);
          row_base <= SW'(row_base + SW'(MAX_WIDTH));
        end else begin
          row      <= '0;
          row_base <= '0;
          if (!frame_last) begin
            frame <= frame + FW'(1);
          end else begin
            frame <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      left_pixel <= '0;
    end else begin
      if (pixel_ready) begin
        s1_valid <= pixel_valid;
      end
      if (accept) begin
        left_pixel <= pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pixel;
      s1_left     <= left_pixel;
      s1_has_left <= (col != '0);
      s1_has_up   <= (row != '0);
      s1_has_prev <= (frame != '0);
      s1_last     <= col_last && row_last && frame_last;
    end
  end

  nat_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pixel),
    .re    (accept),
    .raddr (col),
    .rdata (line_rd)
  );

  nat_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (pixel),
    .re    (accept),
    .raddr (slot),
    .rdata (frame_rd)
  );

  assign pair_inc = 2'(s1_has_left) + 2'(s1_has_up) + 2'(s1_has_prev);
  assign eq_inc   = 2'(s1_has_left && (s1_pixel == s1_left))
                  + 2'(s1_has_up && (s1_pixel == line_rd))
                  + 2'(s1_has_prev && (s1_pixel == frame_rd));
  assign eq_sum    = eq_count + CNT_W'(eq_inc);
  assign pr_sum    = pr_count + CNT_W'(pair_inc);
  assign fin_valid = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      eq_count <= '0;
      pr_count <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        eq_count <= '0;
        pr_count <= '0;
      end else begin
        eq_count <= eq_sum;
        pr_count <= pr_sum;
      end
    end
  end

  nat_verdict #(
    .CNT_W (CNT_W)
  ) u_verdict (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin_ready    (fin_ready),
    .fin_equal    (eq_sum),
    .fin_pairs    (pr_sum),
    .agree_thresh (agree_thresh),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .unit_passes  (unit_passes),
    .equal_pairs  (equal_pairs),
    .total_pairs  (total_pairs)
  );

  `NAT_ASSERT_NOW(a_stall_only_at_unit_end, s1_valid && !s1_go, s1_last, "pixel stage stalled mid-unit")
  `NAT_ASSERT_NEXT(a_count_tracks_pairs, s1_go && !s1_last && !cfg_fire, pr_count == $past(pr_count) + CNT_W'($past(pair_inc)), "pair count lost an update")
  `NAT_ASSERT_NEXT(a_unit_end_clears, s1_go && s1_last, pr_count == '0 && eq_count == '0, "counters not cleared after unit")
  `NAT_ASSERT_NEXT(a_cfg_restarts, cfg_fire, col == '0 && row == '0 && frame == '0 && pr_count == '0, "configuration write did not restart the unit")

endmodule

// ===== src/nat_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/nat_verdict.sv =====
// Verdict pipeline: threshold products, comparison and the result register.
module nat_verdict #(
  parameter int CNT_W = 22
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fin_valid,
  output logic                              fin_ready,
  input  logic [CNT_W-1:0]                  fin_equal,
  input  logic [CNT_W-1:0]                  fin_pairs,
  input  logic [nat_pkg::PERMILLE_BITS-1:0] agree_thresh,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              unit_passes,
  output logic [nat_pkg::COUNT_BITS-1:0]    equal_pairs,
  output logic [nat_pkg::COUNT_BITS-1:0]    total_pairs
);
  import nat_pkg::*;

  localparam int PW = CNT_W + PERMILLE_BITS;

  logic             a_valid;
  logic [CNT_W-1:0] a_equal;
  logic [CNT_W-1:0] a_pairs;
  logic             b_valid;
  logic [CNT_W-1:0] b_equal;
  logic [CNT_W-1:0] b_pairs;
  logic [PW-1:0]    b_lhs;
  logic [PW-1:0]    b_rhs;
  logic             out_free;
  logic             b_ready;

  assign out_free  = !result_valid || result_ready;
  assign b_ready   = !b_valid || out_free;
  assign fin_ready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (fin_ready) begin
        a_valid <= fin_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (out_free) begin
        result_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      a_equal <= fin_equal;
      a_pairs <= fin_pairs;
    end
    if (b_ready && a_valid) begin
      b_equal <= a_equal;
      b_pairs <= a_pairs;
      b_lhs   <= PW'(a_equal) * PW'(PERMILLE_SCALE);
      b_rhs   <= PW'(agree_thresh) * PW'(a_pairs);
    end
    if (out_free && b_valid) begin
      unit_passes <= (b_pairs == '0) || (b_lhs >= b_rhs);
      equal_pairs <= COUNT_BITS'(b_equal);
      total_pairs <= COUNT_BITS'(b_pairs);
    end
  end

endmodule

// ===== tb/sv/nat_verdict_monitor.sv =====
// Watches the neighbour agreement unit's channels, predicts each unit verdict and compares it.
`timescale 1ns / 1ps

module nat_verdict_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  nat_pkg::cfg_index_t               cfg_index,
  input  logic [nat_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              pixel_valid,
  input  logic                              pixel_ready,
  input  logic [nat_pkg::PIXEL_BITS-1:0]    pixel,
  input  logic                              result_valid,
  input  logic                              result_ready,
  input  logic                              unit_passes,
  input  logic [nat_pkg::COUNT_BITS-1:0]    equal_pairs,
  input  logic [nat_pkg::COUNT_BITS-1:0]    total_pairs,
  output int unsigned                       mismatches,
  output int unsigned                       verdicts_owed
);
  import nat_pkg::*;

  typedef struct packed {
    logic                  passes;
    logic [COUNT_BITS-1:0] equal;
    logic [COUNT_BITS-1:0] total;
  } verdict_t;

  verdict_t verdict_queue[$];
  verdict_t got_verdict;
  verdict_t want_verdict;

  logic [WIDTH_BITS-1:0]    width_reg;
  logic [HEIGHT_BITS-1:0]   height_reg;
  logic [FRAMES_BITS-1:0]   frames_reg;
  logic [PERMILLE_BITS-1:0] permille_reg;

  logic [5:0]            col;
  logic [5:0]            row;
  logic [7:0]            frm;
  logic [PIXEL_BITS-1:0] left_pixel_q;
  logic [PIXEL_BITS-1:0] line_mem [DEF_MAX_WIDTH];
  logic [PIXEL_BITS-1:0] frame_mem [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
  logic [COUNT_BITS-1:0] equal_tally;
  logic [COUNT_BITS-1:0] pair_tally;
  int unsigned           fail_total;

  function automatic int unsigned span(int unsigned v, int unsigned ceiling);
    if (v == 0) return 1;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  task automatic restart();
    col = '0;
    row = '0;
    frm = '0;
    equal_tally = '0;
    pair_tally = '0;
  endtask

  task automatic compare_pair(input logic [PIXEL_BITS-1:0] a, input logic [PIXEL_BITS-1:0] b);
    pair_tally = pair_tally + 1'b1;
    if (a == b) equal_tally = equal_tally + 1'b1;
  endtask

  task automatic absorb_pixel(input logic [PIXEL_BITS-1:0] p);
    int unsigned       w;
    int unsigned       h;
    int unsigned       f;
    int unsigned       slot;
    longint unsigned   agree_scaled;
    longint unsigned   needed;
    verdict_t          v;
    w = span(width_reg, DEF_MAX_WIDTH);
    h = span(height_reg, DEF_MAX_HEIGHT);
    f = span(frames_reg, DEF_MAX_FRAMES);
    if (col >= w || row >= h || frm >= f) restart();
    slot = row * DEF_MAX_WIDTH + col;
    if (col != 0) compare_pair(p, left_pixel_q);
    if (row != 0) compare_pair(p, line_mem[col]);
    if (frm != 0) compare_pair(p, frame_mem[slot]);
    left_pixel_q = p;
    line_mem[col] = p;
    frame_mem[slot] = p;
    if (col + 1 < w) begin
      col = col + 1'b1;
      return;
    end
    col = '0;
    if (row + 1 < h) begin
      row = row + 1'b1;
      return;
    end
    row = '0;
    if (frm + 1 < f) begin
      frm = frm + 1'b1;
      return;
    end
    agree_scaled = equal_tally;
    agree_scaled = agree_scaled * PERMILLE_SCALE;
    needed = permille_reg;
    needed = needed * pair_tally;
    v.passes = (pair_tally == 0) || (agree_scaled >= needed);
    v.equal = equal_tally;
    v.total = pair_tally;
    verdict_queue.insert(verdict_queue.size(), v);
    restart();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      frames_reg = RST_FRAME_COUNT;
      permille_reg = RST_AGREE_THRESH;
      left_pixel_q = '0;
      fail_total = 0;
      verdict_queue.delete();
      restart();
    end else begin
      if (result_valid && result_ready) begin
        got_verdict.passes = unit_passes;
        got_verdict.equal = equal_pairs;
        got_verdict.total = total_pairs;
        if (verdict_queue.size() == 0) begin
          $display("%0t: verdict item with none expected: passes=%0b equal=%0d total=%0d",
                   $time, unit_passes, equal_pairs, total_pairs);
          fail_total++;
        end else begin
          want_verdict = verdict_queue.pop_front();
          if (got_verdict !== want_verdict) begin
            $display("%0t: verdict mismatch: expected passes=%0b equal=%0d total=%0d",
                     $time, want_verdict.passes, want_verdict.equal, want_verdict.total);
            $display("%0t:                   actual   passes=%0b equal=%0d total=%0d",
                     $time, got_verdict.passes, got_verdict.equal, got_verdict.total);
            fail_total++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_BITS-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_BITS-1:0];
          REG_FRAME_COUNT:  frames_reg = cfg_data[FRAMES_BITS-1:0];
          REG_AGREE_THRESH: permille_reg = cfg_data[PERMILLE_BITS-1:0];
          default: ;
        endcase
        restart();
      end
      if (pixel_valid && pixel_ready) absorb_pixel(pixel);
    end
    mismatches <= fail_total;
    verdicts_owed <= verdict_queue.size();
  end

endmodule

// ===== tb/sv/tb_neighbour_agreement_test_unit.sv =====
// Top of the neighbour agreement unit testbench: clock, reset, pixel and register stimulus.
`timescale 1ns / 1ps

module tb_neighbour_agreement_test_unit;
  import nat_pkg::*;

  localparam int ITEM_GOAL   = 1950;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 8;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_index_t               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     pixel_valid;
  logic                     pixel_ready;
  logic [PIXEL_BITS-1:0]    pixel;
  logic                     result_valid;
  logic                     result_ready;
  logic                     unit_passes;
  logic [COUNT_BITS-1:0]    equal_pairs;
  logic [COUNT_BITS-1:0]    total_pairs;

  int unsigned mismatches;
  int unsigned verdicts_owed;
  int unsigned items_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned cur_f;

  neighbour_agreement_test_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .unit_passes  (unit_passes),
    .equal_pairs  (equal_pairs),
    .total_pairs  (total_pairs)
  );

  nat_verdict_monitor i_verdict_monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .unit_passes   (unit_passes),
    .equal_pairs   (equal_pairs),
    .total_pairs   (total_pairs),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (cfg_valid && cfg_ready) ||
        (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned span(int unsigned v, int unsigned ceiling);
    if (v == 0) return 1;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  function automatic int unsigned unit_length();
    return span(cur_w, DEF_MAX_WIDTH) * span(cur_h, DEF_MAX_HEIGHT) *
           span(cur_f, DEF_MAX_FRAMES);
  endfunction

  // Unused high data bits are randomised; the register keeps only its own width.
  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'(value);
    case (idx)
      REG_IMAGE_WIDTH: begin
        cur_w = value;
        data = data | CFG_DATA_BITS'($urandom_range(7) << WIDTH_BITS);
      end
      REG_IMAGE_HEIGHT: begin
        cur_h = value;
        data = data | CFG_DATA_BITS'($urandom_range(7) << HEIGHT_BITS);
      end
      REG_FRAME_COUNT: begin
        cur_f = value;
        data = data | CFG_DATA_BITS'($urandom_range(1) << FRAMES_BITS);
      end
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
    while ($urandom_range(99) < gap_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic end_batch();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic stream_pixels(input int unsigned count);
    int unsigned           style;
    logic [PIXEL_BITS-1:0] base;
    logic [PIXEL_BITS-1:0] alt;
    logic [PIXEL_BITS-1:0] value;
    style = $urandom_range(3);
    base = PIXEL_BITS'($urandom);
    alt = PIXEL_BITS'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      case (style)
        0: value = PIXEL_BITS'($urandom);
        1: value = ($urandom_range(9) == 0) ? PIXEL_BITS'($urandom) : base;
        2: value = $urandom_range(1) ? base : alt;
        default: value = ($urandom_range(99) < 97) ? base : alt;
      endcase
      send_pixel(value);
    end
  endtask

  task automatic run_phase(input int unsigned mode);
    int unsigned pick;
    int unsigned new_w;
    int unsigned new_h;
    int unsigned new_f;
    int unsigned new_p;
    int unsigned wrote;
    int unsigned len;
    int unsigned units;
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 87; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 87; end
      default: begin gap_pct = 29; stall_pct = 29; end
    endcase
    new_w = $urandom_range(1, 6);
    new_h = $urandom_range(1, 6);
    new_f = $urandom_range(1, 3);
    pick = $urandom_range(99);
    if (pick < 6) begin
      new_w = $urandom_range(1) ? DEF_MAX_WIDTH : $urandom_range(65, 127);
      new_h = $urandom_range(1, 2);
      new_f = 1;
    end else if (pick < 12) begin
      new_h = $urandom_range(1) ? DEF_MAX_HEIGHT : $urandom_range(65, 127);
      new_w = $urandom_range(1, 2);
      new_f = 1;
    end else if (pick < 17) begin
      new_f = $urandom_range(1) ? DEF_MAX_FRAMES : $urandom_range(257, 511);
      new_w = 1;
      new_h = 1;
    end else if (pick < 22) begin
      if ($urandom_range(1)) new_w = 0;
      if ($urandom_range(1)) new_h = 0;
      if ($urandom_range(1)) new_f = 0;
    end
    case ($urandom_range(9))
      0: new_p = 0;
      1: new_p = 1000;
      2: new_p = $urandom_range(1001, 1023);
      3, 4, 5: new_p = $urandom_range(0, 1000);
      default: new_p = $urandom_range(500, 900);
    endcase
    wrote = 0;
    if ($urandom_range(3) != 0) begin write_reg(REG_IMAGE_WIDTH, new_w); wrote++; end
    if ($urandom_range(3) != 0) begin write_reg(REG_IMAGE_HEIGHT, new_h); wrote++; end
    if ($urandom_range(3) != 0) begin write_reg(REG_FRAME_COUNT, new_f); wrote++; end
    if ($urandom_range(3) != 0 || wrote == 0) write_reg(REG_AGREE_THRESH, new_p);
    cfg_valid <= 1'b0;
    len = unit_length();
    units = (len > 64) ? 1 : $urandom_range(1, 6);
    repeat (units) stream_pixels(len);
    // A unit cut short is abandoned by the register write of the next phase.
    if (len > 1 && $urandom_range(3) == 0) stream_pixels($urandom_range(1, len - 1));
    end_batch();
  endtask

  initial begin
    int unsigned phase;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    pixel_valid <= 1'b0;
    pixel <= '0;
    items_sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    cur_w = RST_IMAGE_WIDTH;
    cur_h = RST_IMAGE_HEIGHT;
    cur_f = RST_FRAME_COUNT;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-pixel units have no pairs and pass whatever the threshold.
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_FRAME_COUNT, 1);
    write_reg(REG_AGREE_THRESH, 600);
    cfg_valid <= 1'b0;
    send_pixel(8'h00);
    send_pixel(8'hFF);
    end_batch();

    // Zero sizes count as one.
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_FRAME_COUNT, 0);
    write_reg(REG_AGREE_THRESH, 1023);
    cfg_valid <= 1'b0;
    send_pixel(8'h55);
    end_batch();

    // A uniform two-frame unit passes at the full threshold and fails above it.
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_FRAME_COUNT, 2);
    write_reg(REG_AGREE_THRESH, 1000);
    cfg_valid <= 1'b0;
    repeat (8) send_pixel(8'hA5);
    end_batch();
    write_reg(REG_AGREE_THRESH, 1023);
    cfg_valid <= 1'b0;
    repeat (8) send_pixel(8'hA5);
    end_batch();

    // With no agreeing pair at all, a zero threshold still passes.
    write_reg(REG_FRAME_COUNT, 1);
    write_reg(REG_AGREE_THRESH, 0);
    cfg_valid <= 1'b0;
    send_pixel(8'h01);
    send_pixel(8'h02);
    send_pixel(8'h04);
    send_pixel(8'h08);
    end_batch();

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      run_phase(phase % 4);
      phase++;
    end
    gap_pct = 0;
    stall_pct = 0;
    end_batch();

    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
